### design/stmp_pkg.sv
// shared widths, matrix type and fixed-point rounding for the scene tree matrix block
package stmp_pkg;

    localparam int NODE_W     = 10;
    localparam int MAX_NODES  = 2 ** NODE_W;
    localparam int WORD_W     = 32;
    localparam int MAT_N      = 9;
    localparam int MAT_W      = MAT_N * WORD_W;
    localparam int PROD_N     = MAT_N * 3;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FRAC_W     = 16;
    localparam int Q_W        = SUM_W - FRAC_W;
    localparam int IN_DATA_W  = ((2 * NODE_W + MAT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((NODE_W + MAT_W + 7) / 8) * 8;

    typedef logic [MAT_N-1:0][WORD_W-1:0] t_mat;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [SUM_W-1:0]      t_sum;

    typedef struct packed {
        logic              sat;
        logic [WORD_W-1:0] val;
    } t_rnd;

    localparam logic [WORD_W-1:0] Q_ONE = WORD_W'(32'h0001_0000);

    localparam t_mat IDENTITY = {Q_ONE, {WORD_W{1'b0}}, {WORD_W{1'b0}},
                                 {WORD_W{1'b0}}, Q_ONE, {WORD_W{1'b0}},
                                 {WORD_W{1'b0}}, {WORD_W{1'b0}}, Q_ONE};

    // round q34.32 sum to nearest q16.16, ties up, then clamp to the word range
    function automatic t_rnd round_clamp(input t_sum s);
        t_sum               t;
        logic [Q_W-1:0]     q;
        t_rnd               r;
        t = s + SUM_W'(1 << (FRAC_W - 1));
        q = t[SUM_W-1:FRAC_W];
        r.sat = !((&q[Q_W-1:WORD_W-1]) || !(|q[Q_W-1:WORD_W-1]));
        if (r.sat) begin
            r.val = q[Q_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            r.val = q[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/scene_tree_matrix_propagate.sv
// scene tree global matrix propagation with per-node matrix store
// path: a request passes the stage 1, stage 2 and output registers, and waits under output stall
// input: a new request is taken only once the previous one has left stage 1, as set by the single
//   read port of the node store and the one-stage forward of the matrix still being written back
// reset: clears the pipeline valids and the output valid; the node store is not cleared
//   and its entries are undefined until written
module scene_tree_matrix_propagate (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // node_index, parent_node, loc_m00 .. loc_m22, zero pad
    input  logic [stmp_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // has_local
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // out_node, glob_m00 .. glob_m22, zero pad
    output logic [stmp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // saturated
    output logic                           o_m_tuser
);
    import stmp_pkg::*;

    logic [MAT_W-1:0] r_mem [MAX_NODES];
    t_mat             r_rd_data;

    logic             w_s_acc;
    logic [NODE_W-1:0] w_in_node;
    logic [NODE_W-1:0] w_in_par;
    t_mat             w_in_loc;

    logic             r_s1_valid;
    logic [NODE_W-1:0] r_s1_node;
    logic             r_s1_root;
    logic             r_s1_local;
    t_mat             r_s1_loc;
    logic             r_s1_fwd_hit;
    t_mat             r_s1_fwd;
    t_mat             w_par;
    t_mat             w_direct;
    t_prod            w_prod [PROD_N];
    logic             w_s1_adv;

    logic             r_s2_valid;
    logic [NODE_W-1:0] r_s2_node;
    logic             r_s2_mult;
    t_mat             r_s2_direct;
    t_prod            r_s2_prod [PROD_N];
    t_mat             w_res;
    logic             w_sat;
    logic             w_s2_adv;

    logic             r_out_valid;
    logic [NODE_W-1:0] r_out_node;
    t_mat             r_out_mat;
    logic             r_out_sat;

    assign o_s_tready = i_rst_n && !r_s1_valid;
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_in_node  = i_s_tdata[NODE_W-1:0];
    assign w_in_par   = i_s_tdata[2*NODE_W-1:NODE_W];
    assign w_in_loc   = i_s_tdata[2*NODE_W +: MAT_W];

    // node store: parent read on request, write back as a result leaves stage 2
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_rd_data <= r_mem[w_in_par];
        end
        if (w_s2_adv) begin
            r_mem[r_s2_node] <= w_res;
        end
    end

    // stage 1 capture, with forward of the result not yet written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_s1_node    <= w_in_node;
            r_s1_root    <= (w_in_node == '0);
            r_s1_local   <= i_s_tuser;
            r_s1_loc     <= w_in_loc;
            r_s1_fwd_hit <= r_s2_valid && (r_s2_node == w_in_par);
            r_s1_fwd     <= w_res;
        end
    end

    assign w_par = r_s1_fwd_hit ? r_s1_fwd : r_rd_data;

    always_comb begin
        if (r_s1_root) begin
            w_direct = r_s1_local ? r_s1_loc : IDENTITY;
        end else begin
            w_direct = w_par;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    w_prod[r*9 + c*3 + k] = $signed(w_par[r*3 + k]) *
                                            $signed(r_s1_loc[k*3 + c]);
                end
            end
        end
    end

    assign w_s1_adv = r_s1_valid && (!r_s2_valid || w_s2_adv);

    // stage 2: products registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s2_valid <= 1'b1;
        end else if (w_s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_node   <= r_s1_node;
            r_s2_mult   <= !r_s1_root && r_s1_local;
            r_s2_direct <= w_direct;
            r_s2_prod   <= w_prod;
        end
    end

    // dot product sums, rounding and clamping
    always_comb begin
        t_sum s;
        t_rnd rc;
        logic any_sat;
        t_mat mres;
        any_sat = 1'b0;
        mres    = '0;
        for (int e = 0; e < MAT_N; e++) begin
            s = SUM_W'(r_s2_prod[3*e]) + SUM_W'(r_s2_prod[3*e + 1]) +
                SUM_W'(r_s2_prod[3*e + 2]);
            rc = round_clamp(s);
            mres[e] = rc.val;
            any_sat = any_sat | rc.sat;
        end
        w_res = r_s2_mult ? mres : r_s2_direct;
        w_sat = r_s2_mult && any_sat;
    end

    assign w_s2_adv = r_s2_valid && (!r_out_valid || i_m_tready);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_out_node <= r_s2_node;
            r_out_mat  <= w_res;
            r_out_sat  <= w_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-NODE_W-MAT_W){1'b0}}, r_out_mat, r_out_node};
    assign o_m_tuser  = r_out_sat;

endmodule

### design/stmp_checker.sv
// port-level checks for the scene tree matrix block, bound to the top level
module stmp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [stmp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                           o_m_tuser
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result shown right after reset");

    // ready goes low after every accepted request
    a_accept_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("requests accepted in consecutive cycles");

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result changed while stalled");

endmodule

bind scene_tree_matrix_propagate stmp_checker u_stmp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

### sim/scene_tree_matrix_propagate_test.sv
// self-checking random and directed testbench for the scene tree matrix propagation block
module scene_tree_matrix_propagate_test;

    localparam int REQ_W      = stmp_pkg::IN_DATA_W;
    localparam int RES_W      = stmp_pkg::OUT_DATA_W;
    localparam int NODE_W     = stmp_pkg::NODE_W;
    localparam int NODES      = stmp_pkg::MAX_NODES;
    localparam int MAT_W      = stmp_pkg::MAT_W;
    localparam int RAND_REQS  = 1950;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_AFTER = 100;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_CYC  = 16;

    typedef enum int {MK_WILD, MK_UNIT, MK_SCALE, MK_DIAG, MK_EDGE, MK_TINY} t_mat_kind;

    typedef struct {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent;
        logic              has_local;
        stmp_pkg::t_mat    loc;
    } t_node_req;

    typedef struct {
        logic [NODE_W-1:0] node;
        stmp_pkg::t_mat    glob;
        logic              sat;
    } t_node_global;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    // node_index, parent_node, loc_m00 .. loc_m22, zero pad
    logic [REQ_W-1:0] i_s_tdata  = '0;
    // has_local
    logic             i_s_tuser  = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    // out_node, glob_m00 .. glob_m22, zero pad
    logic [RES_W-1:0] o_m_tdata;
    // saturated
    logic             o_m_tuser;

    t_node_req        node_reqs[$];
    t_node_global     pending_globals[$];
    stmp_pkg::t_mat   node_globals [NODES];

    logic             gen_written [NODES];
    int               gen_written_list[$];
    int               gen_recent[$];

    t_node_req        drv_req;
    int               send_wait   = 0;
    logic             send_burst  = 1'b0;
    int               recv_wait   = 0;
    logic             recv_burst  = 1'b0;
    logic             rx_hold     = 1'b0;
    int               reqs_accepted = 0;
    int               fail_count  = 0;
    int               idle_cycles = 0;

    string field_names [11] = '{"out_node", "glob_m00", "glob_m01", "glob_m02", "glob_m10",
                                "glob_m11", "glob_m12", "glob_m20", "glob_m21", "glob_m22",
                                "saturated"};

    scene_tree_matrix_propagate DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // global matrix of one request, updates the node store
    function automatic t_node_global propagate_node(input logic [REQ_W-1:0] d,
                                                    input logic has_local);
        logic [NODE_W-1:0]  parent;
        stmp_pkg::t_mat     loc;
        stmp_pkg::t_mat     par;
        t_node_global       g;
        logic signed [65:0] acc;
        int                 r;
        int                 c;
        int                 k;
        g.node = d[NODE_W-1:0];
        parent = d[2*NODE_W-1:NODE_W];
        loc    = d[2*NODE_W +: MAT_W];
        g.sat  = 1'b0;
        if (g.node == 0) begin
            for (k = 0; k < 9; k++) begin
                g.glob[k] = has_local ? loc[k] : ((k % 4 == 0) ? stmp_pkg::Q_ONE : 32'd0);
            end
        end else begin
            par = node_globals[parent];
            if (!has_local) begin
                g.glob = par;
            end else begin
                for (r = 0; r < 3; r++) begin
                    for (c = 0; c < 3; c++) begin
                        acc = 66'sd32768;
                        for (k = 0; k < 3; k++) begin
                            acc += 66'($signed(par[r*3+k])) * 66'($signed(loc[k*3+c]));
                        end
                        acc = acc >>> 16;
                        if (acc > 66'sd2147483647) begin
                            g.sat = 1'b1;
                            g.glob[r*3+c] = 32'h7FFF_FFFF;
                        end else if (acc < -66'sd2147483648) begin
                            g.sat = 1'b1;
                            g.glob[r*3+c] = 32'h8000_0000;
                        end else begin
                            g.glob[r*3+c] = acc[31:0];
                        end
                    end
                end
            end
        end
        node_globals[g.node] = g.glob;
        return g;
    endfunction

    function automatic stmp_pkg::t_mat fill_mat(input logic [31:0] v);
        stmp_pkg::t_mat m;
        int             k;
        for (k = 0; k < 9; k++) m[k] = v;
        return m;
    endfunction

    function automatic stmp_pkg::t_mat diag_mat(input logic [31:0] v);
        stmp_pkg::t_mat m;
        int             k;
        for (k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? v : 32'd0;
        return m;
    endfunction

    function automatic stmp_pkg::t_mat random_mat();
        stmp_pkg::t_mat m;
        t_mat_kind      kind;
        logic [31:0]    edges [5];
        int             k;
        edges = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF};
        kind = t_mat_kind'($urandom_range(0, 5));
        for (k = 0; k < 9; k++) begin
            case (kind)
                MK_WILD:  m[k] = $urandom;
                MK_UNIT:  m[k] = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
                MK_SCALE: m[k] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
                MK_DIAG:  m[k] = (k % 4 == 0) ? $urandom_range(0, 32'h0002_0000) - 32'h0001_0000
                                              : $urandom_range(0, 32'h2000) - 32'h1000;
                MK_EDGE:  m[k] = edges[$urandom_range(0, 4)];
                default:  m[k] = $urandom_range(0, 32'h200) - 32'h100;
            endcase
        end
        return m;
    endfunction

    task automatic push_req(input int node, input int parent, input logic has_local,
                            input stmp_pkg::t_mat loc);
        t_node_req req;
        req.node      = NODE_W'(node);
        req.parent    = NODE_W'(parent);
        req.has_local = has_local;
        req.loc       = loc;
        node_reqs = {node_reqs, req};
        if (!gen_written[node]) begin
            gen_written[node] = 1'b1;
            gen_written_list = {gen_written_list, node};
        end
        gen_recent = {gen_recent, node};
        if (gen_recent.size() > 8) void'(gen_recent.pop_front());
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (send_wait > 0 || node_reqs.size() == 0) begin
                if (send_wait > 0) send_wait--;
                i_s_tvalid <= 1'b0;
            end else begin
                drv_req = node_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= REQ_W'({drv_req.loc, drv_req.parent, drv_req.node});
                i_s_tuser  <= drv_req.has_local;
                if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
                send_wait = send_burst ? 0 : $urandom_range(0, 15);
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, 15);
            end
            if (rx_hold) begin
                i_m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // long output stall so the block backs up into its input
    initial begin
        wait (reqs_accepted >= HOLD_AFTER);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // monitor: checks results against the oldest expectation, predicts on each request
    always @(posedge i_clk) begin
        t_node_global want;
        logic [31:0]  want_f [11];
        logic [31:0]  got_f  [11];
        int           bad;
        int           k;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_globals.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result for node %0d", o_m_tdata[NODE_W-1:0]);
                end
            end else begin
                want = pending_globals.pop_front();
                want_f[0]  = 32'(want.node);
                got_f[0]   = 32'(o_m_tdata[NODE_W-1:0]);
                for (k = 0; k < 9; k++) begin
                    want_f[k+1] = want.glob[k];
                    got_f[k+1]  = o_m_tdata[NODE_W + 32*k +: 32];
                end
                want_f[10] = 32'(want.sat);
                got_f[10]  = 32'(o_m_tuser);
                bad = -1;
                for (k = 0; k < 11; k++) begin
                    if (bad < 0 && got_f[k] !== want_f[k]) bad = k;
                end
                if (bad >= 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch node %0d %s: expected %h got %h",
                                 want.node, field_names[bad], want_f[bad], got_f[bad]);
                    end
                end
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            pending_globals = {pending_globals, propagate_node(i_s_tdata, i_s_tuser)};
            reqs_accepted++;
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        stmp_pkg::t_mat m;
        int             n;
        int             node;
        int             parent;
        int             back;

        foreach (gen_written[k]) gen_written[k] = 1'b0;

        // root without local, then a plain product and a copy
        push_req(0, 0, 1'b0, random_mat());
        push_req(1, 0, 1'b1, fill_mat($urandom));
        push_req(1023, 1, 1'b0, random_mat());
        // saturation in both directions against a maximal and then a minimal root
        push_req(0, 1023, 1'b1, fill_mat(32'h7FFF_FFFF));
        push_req(2, 0, 1'b1, fill_mat(32'h7FFF_FFFF));
        push_req(3, 0, 1'b1, fill_mat(32'h8000_0000));
        push_req(4, 0, 1'b1, fill_mat(32'h0));
        push_req(0, 3, 1'b1, fill_mat(32'h8000_0000));
        push_req(5, 0, 1'b1, fill_mat(32'h8000_0000));
        // rounding ties through a half-scale parent
        push_req(0, 5, 1'b0, fill_mat($urandom));
        push_req(6, 0, 1'b1, diag_mat(32'h0000_8000));
        m[0] = 32'd1;          m[1] = 32'hFFFF_FFFF; m[2] = 32'd3;
        m[3] = 32'hFFFF_FFFD;  m[4] = 32'h7FFF_FFFF; m[5] = 32'h8000_0000;
        m[6] = 32'd2;          m[7] = 32'hFFFF_FFFE; m[8] = 32'd5;
        push_req(7, 6, 1'b1, m);
        // parent is the node itself
        push_req(7, 7, 1'b1, diag_mat(32'h0001_0000));
        push_req(8, 7, 1'b0, random_mat());
        push_req(1022, 1023, 1'b1, random_mat());
        push_req(1023, 1022, 1'b1, random_mat());
        push_req(9, 1022, 1'b1, fill_mat(32'hFFFF_FFFF));
        // clamp boundary with a parent scale of two
        push_req(11, 0, 1'b1, diag_mat(32'h0002_0000));
        push_req(12, 11, 1'b1, diag_mat(32'h3FFF_FFFF));
        push_req(13, 11, 1'b1, diag_mat(32'h4000_0000));
        push_req(14, 11, 1'b1, diag_mat(32'hC000_0000));
        push_req(15, 11, 1'b1, diag_mat(32'hBFFF_FFFF));

        for (n = 0; n < RAND_REQS; n++) begin
            if ($urandom_range(0, 12) == 0) begin
                node = 0;
            end else begin
                node = $urandom_range(1, NODES - 1);
            end
            if ($urandom_range(0, 1) == 1) begin
                back   = $urandom_range(0, gen_recent.size() - 1);
                parent = gen_recent[gen_recent.size() - 1 - back];
            end else begin
                parent = gen_written_list[$urandom_range(0, gen_written_list.size() - 1)];
            end
            push_req(node, parent, $urandom_range(0, 3) != 0, random_mat());
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (node_reqs.size() != 0 || i_s_tvalid || pending_globals.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### scene_tree_matrix_propagate.f
design/stmp_pkg.sv
design/scene_tree_matrix_propagate.sv
design/stmp_checker.sv
sim/scene_tree_matrix_propagate_test.sv
